@@ design/kvt_pkg.sv @@
// Shared types and constants for the key/value table with expiry.
// Used by kvt_controller, kvt_datapath and key_value_table_with_expiry_core.
`timescale 1ns / 1ps

package kvt_pkg;

   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int LIFE_W = 32;
   localparam int TIME_W = 64;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_GET    = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic valid;
      logic [KEY_W-1:0] key;
      logic [DATA_W-1:0] data;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic cnt_zero;
      logic cnt_step;
      logic rd_en;
      logic clear_wr;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic req_scan;
      logic out_free;
   } status_type;

endpackage

@@ design/kvt_controller.sv @@
// Sequencer for the key/value table: clear sweep, table scan and commit.
// Depends on kvt_pkg; drives kvt_datapath through cmd_type, reads status_type.
`timescale 1ns / 1ps

module kvt_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  kvt_pkg::status_type status,
   output kvt_pkg::cmd_type    cmd
);
   import kvt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.req_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (status.cnt_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.cnt_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.capture = req_tvalid;
            cmd.cnt_zero = req_tvalid;
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.cnt_step = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            cmd.commit = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ design/kvt_datapath.sv @@
// Entry memory, scan compare, time counter and result register of the table.
// Depends on kvt_pkg; commanded by kvt_controller.
`timescale 1ns / 1ps

module kvt_datapath #(
   parameter int ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [103:0]        req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,
   input  kvt_pkg::cmd_type    cmd,
   output kvt_pkg::status_type status
);
   import kvt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   entry_type mem [ENTRIES];

   logic [IDX_W-1:0]  cnt_ff;
   logic [1:0]        act_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] data_ff;
   logic [TIME_W-1:0] deadline_ff;
   logic [TIME_W-1:0] now_ff;

   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   entry_type         rd_word_ff;

   logic              match_found_ff;
   logic              match_live_ff;
   logic [IDX_W-1:0]  match_idx_ff;
   logic [DATA_W-1:0] match_data_ff;
   logic              free_found_ff;
   logic [IDX_W-1:0]  free_idx_ff;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_full_ff;

   logic [1:0]        req_action;
   logic [LIFE_W-1:0] req_life;
   logic [TIME_W:0]   deadline_sum;
   logic [TIME_W-1:0] deadline_in;
   logic              key_hit;
   logic              slot_live;
   logic              ins_ok;
   logic              get_hit;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_word;

   assign req_action = req_tdata[1:0];
   assign req_life = req_tdata[97:66];

   assign deadline_sum = {1'b0, now_ff} + (TIME_W + 1)'(req_life);
   assign deadline_in = deadline_sum[TIME_W] ? '1 : deadline_sum[TIME_W-1:0];

   assign key_hit = rd_word_ff.valid && (rd_word_ff.key == key_ff);
   assign slot_live = rd_word_ff.valid && (rd_word_ff.deadline >= now_ff);

   assign ins_ok = match_found_ff || free_found_ff;
   assign get_hit = match_found_ff && match_live_ff;
   assign wr_en = cmd.clear_wr || (cmd.commit && (act_ff == ACT_INSERT) && ins_ok);
   assign wr_addr = cmd.clear_wr ? cnt_ff : (match_found_ff ? match_idx_ff : free_idx_ff);

   always_comb begin
      wr_word = '0;
      if (!cmd.clear_wr) begin
         wr_word.valid = 1'b1;
         wr_word.key = key_ff;
         wr_word.data = data_ff;
         wr_word.deadline = deadline_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      rd_word_ff <= mem[cnt_ff];
      rd_idx_ff <= cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_valid_ff <= 1'b0;
         now_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cnt_zero) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         rd_valid_ff <= cmd.rd_en;
         if (cmd.commit && (act_ff == ACT_TICK) && (now_ff != '1)) begin
            now_ff <= now_ff + 1'b1;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         key_ff <= req_tdata[33:2];
         data_ff <= req_tdata[65:34];
         deadline_ff <= deadline_in;
         match_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (rd_valid_ff) begin
         if (key_hit && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff <= rd_idx_ff;
            match_live_ff <= slot_live;
            match_data_ff <= rd_word_ff.data;
         end
         if (!slot_live && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         case (act_ff)
            ACT_INSERT: begin
               rsp_hit_ff <= 1'b0;
               rsp_value_ff <= '0;
               rsp_full_ff <= !ins_ok;
            end
            ACT_GET: begin
               rsp_hit_ff <= get_hit;
               rsp_value_ff <= get_hit ? match_data_ff : '0;
               rsp_full_ff <= 1'b0;
            end
            default: begin
               rsp_hit_ff <= 1'b0;
               rsp_value_ff <= '0;
               rsp_full_ff <= 1'b0;
            end
         endcase
      end
   end

   assign status.cnt_last = (cnt_ff == LAST_IDX);
   assign status.req_scan = (req_action == ACT_INSERT) || (req_action == ACT_GET);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'b0, rsp_full_ff, rsp_value_ff, rsp_hit_ff};

endmodule

@@ design/key_value_table_with_expiry_core.sv @@
// Key/value table with expiry: top level joining kvt_controller and kvt_datapath.
// Depends on kvt_pkg, kvt_controller and kvt_datapath.
//
// Usage:
//   The req_ stream carries one command per transfer: insert, get or tick.
//   Every command yields exactly one transfer on the rsp_ stream, in order.
//   Insert and get scan the entry memory, one entry per cycle through its
//   single read port, before the result is committed; a tick or an unused
//   code skips the scan and goes straight to the commit.
//   Commands are handled one at a time: req_tready is high only while the
//   sequencer is idle, so a new command is taken only after the previous
//   one has committed its result. The next command may be taken while the
//   previous result still waits in the output register.
//   When rsp_tready is low and the result register is full, the finished
//   command holds in its final state until the register frees up.
//   After reset a clearing pass marks every entry invalid; req_tready stays
//   low until it ends. The time counter resets to zero.
`timescale 1ns / 1ps

module key_value_table_with_expiry_core #(
   parameter int ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[1:0], lookup_key[33:2], data_value[65:34], lifetime[97:66], zero pad
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit[0], read_value[32:1], table_full[33], zero pad
   output logic [39:0]  rsp_tdata
);
   import kvt_pkg::*;

   cmd_type    cmd;
   status_type status;

   kvt_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kvt_datapath #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("command accepted while another is in progress");

   a_hit_full_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[33]))
      else $error("hit and table_full both set");

   a_miss_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[32:1] == 32'd0))
      else $error("nonzero value without a hit");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for key_value_table_with_expiry_core: directed rows, then random.
// Holds its own model of the keyed table, the deadlines and the tick counter; depends on kvt_pkg.
`timescale 1ns / 1ps

module testbench;
   import kvt_pkg::*;

   localparam int TBL_ENTRIES = 16;
   localparam int ITEM_TARGET = 1750;
   localparam int POOL_SIZE = 24;
   localparam int DIR_ROWS = 23;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic hit;
      logic [DATA_W-1:0] value;
      logic full;
   } kv_result_type;

   typedef struct packed {
      logic [1:0] act;
      logic [KEY_W-1:0] key;
      logic [DATA_W-1:0] data;
      logic [LIFE_W-1:0] life;
      logic typed;
      kv_result_type res;
   } kv_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // action[1:0], lookup_key[33:2], data_value[65:34], lifetime[97:66], zero pad
   logic [103:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // hit[0], read_value[32:1], table_full[33], zero pad
   logic [39:0] rsp_tdata;

   logic tbl_valid [TBL_ENTRIES];
   logic [KEY_W-1:0] tbl_key [TBL_ENTRIES];
   logic [DATA_W-1:0] tbl_data [TBL_ENTRIES];
   logic [TIME_W-1:0] tbl_deadline [TBL_ENTRIES];
   logic [TIME_W-1:0] now_ticks;

   kv_result_type kv_expected [$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   kv_row_type dir_rows [0:DIR_ROWS-1];

   int err_count = 0;
   int items_sent = 0;
   int rsp_count = 0;
   int n_insert = 0;
   int n_get = 0;
   int n_tick = 0;
   int n_hit = 0;
   int n_full = 0;
   bit calm_run = 0;

   key_value_table_with_expiry_core #(.ENTRIES(TBL_ENTRIES)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic kv_result_type kv_predict(input logic [1:0] act,
                                                input logic [KEY_W-1:0] key,
                                                input logic [DATA_W-1:0] data,
                                                input logic [LIFE_W-1:0] life);
      kv_result_type r;
      int slot;
      int i;
      logic [TIME_W-1:0] deadline;
      r = '0;
      slot = -1;
      case (act)
         ACT_INSERT: begin
            deadline = now_ticks + {32'd0, life};
            if (deadline < now_ticks) deadline = '1;
            for (i = 0; i < TBL_ENTRIES; i++)
               if (slot < 0 && tbl_valid[i] && tbl_key[i] == key) slot = i;
            for (i = 0; i < TBL_ENTRIES; i++)
               if (slot < 0 && !(tbl_valid[i] && tbl_deadline[i] >= now_ticks)) slot = i;
            if (slot >= 0) begin
               tbl_valid[slot] = 1'b1;
               tbl_key[slot] = key;
               tbl_data[slot] = data;
               tbl_deadline[slot] = deadline;
            end else begin
               r.full = 1'b1;
            end
         end
         ACT_GET: begin
            for (i = 0; i < TBL_ENTRIES; i++)
               if (slot < 0 && tbl_valid[i] && tbl_key[i] == key) slot = i;
            if (slot >= 0 && tbl_deadline[slot] >= now_ticks) begin
               r.hit = 1'b1;
               r.value = tbl_data[slot];
            end
         end
         ACT_TICK: begin
            if (now_ticks != '1) now_ticks = now_ticks + 64'd1;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_cmd(input logic [1:0] act, input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] data, input logic [LIFE_W-1:0] life,
                           input logic typed, input kv_result_type typed_res);
      kv_result_type r;
      if (!calm_run && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, life, data, key, act};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      r = kv_predict(act, key, data, life);
      kv_expected.push_back(typed ? typed_res : r);
      items_sent++;
      case (act)
         ACT_INSERT: n_insert++;
         ACT_GET: n_get++;
         ACT_TICK: n_tick++;
         default: ;
      endcase
   endtask

   function automatic logic [LIFE_W-1:0] pick_life();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 10);
      if (r < 90) return $urandom_range(0, 60);
      return $urandom;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // stimulus
   initial begin
      int i;
      int j;
      int n;
      int s;
      int r;
      bit paused;
      logic [1:0] act;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      paused = 0;
      for (i = 0; i < TBL_ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i] = '0;
         tbl_data[i] = '0;
         tbl_deadline[i] = '0;
      end
      now_ticks = '0;
      for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;

      dir_rows = '{
         '{ACT_GET,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
           '{1'b0, 32'h0000_0000, 1'b0}},
         '{ACT_TICK,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
           '{1'b0, 32'h0000_0000, 1'b0}},
         '{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
           '{1'b0, 32'h0000_0000, 1'b0}},
         '{ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
           '{1'b0, 32'h0000_0000, 1'b0}},
         '{ACT_GET,    32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
           '{1'b1, 32'h7FFF_FFFF, 1'b0}},
         '{ACT_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
           '{1'b0, 32'h0000_0000, 1'b0}},
         '{ACT_GET,    32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1,
           '{1'b1, 32'h8000_0000, 1'b0}},
         '{ACT_TICK,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
           '{1'b0, 32'h0000_0000, 1'b0}},
         '{ACT_GET,    32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
           '{1'b0, 32'h0000_0000, 1'b0}},
         '{ACT_INSERT, 32'h8000_0000, 32'h0000_0005, 32'h0000_0003, 1'b0, '0},
         '{ACT_GET,    32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
         '{ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
         '{ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b0, '0},
         '{ACT_GET,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
         '{ACT_GET,    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
         '{ACT_TICK,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
         '{ACT_GET,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
         '{ACT_GET,    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
         '{ACT_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 32'h0000_0002, 1'b0, '0},
         '{ACT_GET,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
         '{ACT_GET,    32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
         '{ACT_UNUSED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
           '{1'b0, 32'h0000_0000, 1'b0}},
         '{ACT_GET,    32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         send_cmd(dir_rows[i].act, dir_rows[i].key, dir_rows[i].data, dir_rows[i].life,
                  dir_rows[i].typed, dir_rows[i].res);

      while (items_sent < ITEM_TARGET) begin
         calm_run = (items_sent >= 400 && items_sent < 700);
         if (!paused && items_sent >= 1000) begin
            // hold off until the table has answered everything
            paused = 1;
            req_tvalid <= 1'b0;
            while (kv_expected.size() != 0) @(posedge clock);
         end
         r = $urandom_range(0, 9);
         if (r <= 5) begin
            n = $urandom_range(10, 40);
            for (j = 0; j < n; j++) begin
               s = $urandom_range(0, 99);
               act = (s < 40) ? ACT_INSERT : (s < 78) ? ACT_GET : (s < 95) ? ACT_TICK
                                                              : ACT_UNUSED;
               send_cmd(act, pick_key(), $urandom, pick_life(), 1'b0, '0);
            end
         end else if (r <= 7) begin
            // eighteen distinct live keys overflow the sixteen slots
            s = $urandom_range(0, POOL_SIZE - 1);
            for (j = 0; j < 18; j++)
               send_cmd(ACT_INSERT, key_pool[(s + j) % POOL_SIZE], $urandom,
                        $urandom_range(5, 40), 1'b0, '0);
            for (j = 0; j < 6; j++)
               send_cmd(ACT_GET, key_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom,
                        $urandom, 1'b0, '0);
         end else if (r == 8) begin
            n = $urandom_range(1, 30);
            for (j = 0; j < n; j++) send_cmd(ACT_TICK, $urandom, $urandom, $urandom, 1'b0, '0);
         end else begin
            n = $urandom_range(5, 15);
            for (j = 0; j < n; j++)
               send_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, 1'b0, '0);
         end
      end
      calm_run = 0;
      req_tvalid <= 1'b0;

      while (kv_expected.size() != 0) @(posedge clock);
      repeat (4 * TBL_ENTRIES) @(posedge clock);

      $display("Sent %0d commands: %0d inserts, %0d gets, %0d ticks, rest unused codes.",
               items_sent, n_insert, n_get, n_tick);
      $display("Checked %0d responses: %0d get hits, %0d inserts dropped on a full table.",
               rsp_count, n_hit, n_full);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // response checker
   initial begin
      kv_result_type exp_res;
      bit held;
      held = 0;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            rsp_count++;
            if (rsp_tdata[0]) n_hit++;
            if (rsp_tdata[33]) n_full++;
            if (kv_expected.size() == 0) begin
               err_count++;
               $display("%0t: transfer with nothing pending, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               exp_res = kv_expected.pop_front();
               if (rsp_tdata[0] !== exp_res.hit) begin
                  err_count++;
                  $display("%0t: hit mismatch, expected %0b actual %0b",
                           $time, exp_res.hit, rsp_tdata[0]);
               end
               if (rsp_tdata[32:1] !== exp_res.value) begin
                  err_count++;
                  $display("%0t: read_value mismatch, expected %h actual %h",
                           $time, exp_res.value, rsp_tdata[32:1]);
               end
               if (rsp_tdata[33] !== exp_res.full) begin
                  err_count++;
                  $display("%0t: table_full mismatch, expected %0b actual %0b",
                           $time, exp_res.full, rsp_tdata[33]);
               end
            end
         end
         if (!held && rsp_count >= 300) begin
            // stall the output long enough to back up the request side
            held = 1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_tready <= calm_run || ($urandom_range(0, 99) >= 20);
      end
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d responses still pending", kv_expected.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
design/kvt_pkg.sv
design/kvt_controller.sv
design/kvt_datapath.sv
design/key_value_table_with_expiry_core.sv
tb/testbench.sv
